FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the button press classifier modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clk edge outside reset; expects clk and rst_n in scope.
`define BPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clk edge, reset included.
`define BPC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/bpc_pkg.sv
// Package: shared constants and controller/datapath interface types.
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int CNT_W = 17;
    localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1FFFF;

    localparam int CFG_W = 16;
    localparam int ADDR_W = 3;

    // configuration register indexes
    localparam logic [ADDR_W-1:0] REG_LONG_PRESS  = 3'd0;
    localparam logic [ADDR_W-1:0] REG_SHORT_PRESS = 3'd1;
    localparam logic [ADDR_W-1:0] REG_IDLE        = 3'd2;
    localparam logic [ADDR_W-1:0] REG_REPEAT      = 3'd3;
    localparam logic [ADDR_W-1:0] REG_SEQ_ENABLE  = 3'd4;

    localparam logic [CFG_W-1:0] LONG_PRESS_RST  = 16'd300;
    localparam logic [CFG_W-1:0] SHORT_PRESS_RST = 16'd1;
    localparam logic [CFG_W-1:0] IDLE_RST        = 16'd40;
    localparam logic [CFG_W-1:0] REPEAT_RST      = 16'd0;

    // release classification
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_DOT  = 2'd1;
    localparam logic [1:0] KIND_DASH = 2'd2;

    // remainder unit: one quotient bit per cycle over the 17-bit offset
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] DIV_LAST_STEP = 5'd16;

    typedef struct packed {
        logic load;       // latch the input beat
        logic div_start;  // seed the remainder unit
        logic div_step;   // one restoring iteration
        logic commit;     // update state, load output register
    } bpc_cmd_t;

    typedef struct packed {
        logic need_div;   // this tick needs the repeat remainder
        logic div_done;   // last iteration is running
        logic out_free;   // output register can take a result
    } bpc_status_t;

endpackage

FILE: rtl/core/button_press_classifier.sv
// Top level: button short/long press classifier with repeat and mark sequences.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready, button_level): one beat per button tick.
//   Output channel (out_valid/out_ready): exactly one result beat per input
//   beat, in order: short_press, long_press, click_kind, sequence_valid,
//   sequence_length, sequence_marks.
//   Config port (cfg_wr_en/cfg_addr/cfg_wdata): single-cycle register write,
//   index 0 long press, 1 short press, 2 idle, 3 repeat, 4 sequence enable.
//   Unknown indexes are dropped; data is masked to the register width.
// Timing
//   One beat at a time. Accept, evaluate, commit: out_valid rises at the
//   commit edge, which follows evaluation. While the button stays held
//   past the long press point with a nonzero repeat interval, the repeat check
//   runs a restoring remainder unit between evaluation and commit, one bit per
//   cycle. in_ready rises with out_valid, at the commit edge.
// Reset
//   rst_n clears press state, counters and the mark buffer, loads register
//   defaults (300, 1, 40, 0, disabled) and empties the output register.
// Backpressure
//   The output register holds a result until out_ready. The next beat is
//   still accepted and evaluated; its commit waits for the register to free.

module button_press_classifier #(
    parameter int MAX_MARKS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [bpc_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [bpc_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        button_level,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        short_press,
    output logic                        long_press,
    output logic [1:0]                  click_kind,
    output logic                        sequence_valid,
    output logic [4:0]                  sequence_length,
    output logic [15:0]                 sequence_marks
);

    bpc_pkg::bpc_cmd_t    cmd;
    bpc_pkg::bpc_status_t status;

    // sequencer: one beat in flight
    bpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // counters, mark buffer, remainder unit and output register
    bpc_datapath #(
        .MAX_MARKS (MAX_MARKS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .button_level    (button_level),
        .cmd             (cmd),
        .status          (status),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .short_press     (short_press),
        .long_press      (long_press),
        .click_kind      (click_kind),
        .sequence_valid  (sequence_valid),
        .sequence_length (sequence_length),
        .sequence_marks  (sequence_marks)
    );

endmodule

FILE: rtl/core/bpc_ctrl.sv
// Controller: sequences accept, evaluation, remainder iterations and commit.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bpc_pkg::bpc_status_t status,
    output bpc_pkg::bpc_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EVAL   = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd.load      = in_valid && (state_reg == ST_IDLE);
        cmd.div_start = (state_reg == ST_EVAL) && status.need_div;
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.commit    = (state_reg == ST_COMMIT) && status.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = status.need_div ? ST_DIV : ST_COMMIT;
            end
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    `BPC_ASSERT(a_accept_to_eval, in_valid && in_ready |=> state_reg == ST_EVAL,
        "accepted beat did not move to evaluation")
    `BPC_ASSERT(a_start_to_div, cmd.div_start |=> state_reg == ST_DIV && !in_ready,
        "remainder unit started without entering iteration")
    `BPC_ASSERT(a_commit_to_idle, cmd.commit |=> in_ready,
        "commit did not reopen the input")

endmodule

FILE: rtl/core/bpc_datapath.sv
// Datapath: config registers, press state, repeat remainder unit, output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpc_datapath #(
    parameter int MAX_MARKS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [bpc_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [bpc_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        button_level,
    input  bpc_pkg::bpc_cmd_t           cmd,
    output bpc_pkg::bpc_status_t        status,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic                        short_press,
    output logic                        long_press,
    output logic [1:0]                  click_kind,
    output logic                        sequence_valid,
    output logic [4:0]                  sequence_length,
    output logic [15:0]                 sequence_marks
);

    localparam int CW = $clog2(MAX_MARKS + 1);
    localparam int SHOW = (MAX_MARKS < 16) ? MAX_MARKS : 16;
    localparam int CNT_W = bpc_pkg::CNT_W;

    // configuration
    logic [15:0] long_reg, short_reg, idle_reg, rep_reg;
    logic        seq_en_reg;

    // press state
    logic                 lvl_reg;
    logic                 prev_reg, prev_next;
    logic [CNT_W-1:0]     held_reg, held_next;
    logic [CNT_W-1:0]     rel_reg, rel_next;
    logic [CW-1:0]        mcount_reg, mcount_next;
    logic [MAX_MARKS-1:0] mbits_reg, mbits_next;

    // remainder unit
    logic [15:0]          rem_reg;
    logic [CNT_W-1:0]     dvd_reg;
    logic [bpc_pkg::STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]     rem_sh;
    logic [CNT_W:0]       trial;

    // output register
    logic        out_valid_reg;
    logic        sp_reg, lp_reg, sv_reg;
    logic [1:0]  kind_reg;
    logic [4:0]  slen_reg;
    logic [15:0] smarks_reg;

    logic        sp_next, lp_next, sv_next;
    logic [1:0]  kind_next;
    logic [4:0]  slen_next;
    logic [15:0] smarks_next;

    logic [CNT_W-1:0] long_ext, short_ext, idle_ext;
    logic both_low, rise, hold, fall, held_live;

    assign long_ext  = {1'b0, long_reg};
    assign short_ext = {1'b0, short_reg};
    assign idle_ext  = {1'b0, idle_reg};

    assign both_low  = !lvl_reg && !prev_reg;
    assign rise      = lvl_reg && !prev_reg;
    assign hold      = lvl_reg && prev_reg;
    assign fall      = !lvl_reg && prev_reg;
    assign held_live = (held_reg != bpc_pkg::COUNT_MAX);

    always_comb
    begin
        status.need_div = hold && held_live && (rep_reg != 16'd0)
                          && (held_reg > long_ext);
        status.div_done = (step_reg == bpc_pkg::DIV_LAST_STEP);
        status.out_free = !out_valid_reg || out_ready;
    end

    // restoring remainder step: rem stays below the 16-bit divisor
    assign rem_sh = {rem_reg, dvd_reg[CNT_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, rep_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= 16'd0;
            dvd_reg <= held_reg - long_ext;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial[CNT_W] ? rem_sh[15:0] : trial[15:0];
            dvd_reg <= {dvd_reg[CNT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (cmd.div_start)
            step_reg <= '0;
        else if (cmd.div_step)
            step_reg <= step_reg + bpc_pkg::STEP_W'(1);
    end

    always_comb
    begin
        prev_next   = lvl_reg;
        held_next   = held_reg;
        rel_next    = rel_reg;
        mcount_next = mcount_reg;
        mbits_next  = mbits_reg;
        sp_next     = 1'b0;
        lp_next     = 1'b0;
        kind_next   = bpc_pkg::KIND_NONE;
        sv_next     = 1'b0;
        slen_next   = 5'd0;
        smarks_next = 16'd0;

        if (both_low)
        begin
            if (mcount_reg != '0)
            begin
                if (rel_reg > idle_ext)
                begin
                    if (seq_en_reg)
                    begin
                        sv_next     = 1'b1;
                        slen_next   = (32'(mcount_reg) > 32'd31) ? 5'd31 : 5'(mcount_reg);
                        smarks_next = 16'(mbits_reg[SHOW-1:0]);
                    end
                    mcount_next = '0;
                    mbits_next  = '0;
                    rel_next    = '0;
                end
                else if (rel_reg != bpc_pkg::COUNT_MAX)
                begin
                    rel_next = rel_reg + CNT_W'(1);
                end
            end
            else
            begin
                rel_next = '0;
            end
        end
        else if (rise)
        begin
            held_next = '0;
        end
        else if (hold)
        begin
            if (held_live)
            begin
                sp_next   = (held_reg == short_ext);
                lp_next   = (held_reg == long_ext)
                            || (status.need_div && (rem_reg == 16'd0));
                held_next = held_reg + CNT_W'(1);
            end
        end
        else if (fall)
        begin
            if (held_reg > long_ext)
                kind_next = bpc_pkg::KIND_DASH;
            else if (held_reg > short_ext)
                kind_next = bpc_pkg::KIND_DOT;
            if ((kind_next != bpc_pkg::KIND_NONE) && seq_en_reg
                && (32'(mcount_reg) < MAX_MARKS))
            begin
                if (kind_next == bpc_pkg::KIND_DASH)
                    mbits_next = mbits_reg | (MAX_MARKS'(1) << mcount_reg);
                mcount_next = mcount_reg + CW'(1);
            end
            rel_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_reg   <= bpc_pkg::LONG_PRESS_RST;
            short_reg  <= bpc_pkg::SHORT_PRESS_RST;
            idle_reg   <= bpc_pkg::IDLE_RST;
            rep_reg    <= bpc_pkg::REPEAT_RST;
            seq_en_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                bpc_pkg::REG_LONG_PRESS:  long_reg   <= cfg_wdata;
                bpc_pkg::REG_SHORT_PRESS: short_reg  <= cfg_wdata;
                bpc_pkg::REG_IDLE:        idle_reg   <= cfg_wdata;
                bpc_pkg::REG_REPEAT:      rep_reg    <= cfg_wdata;
                bpc_pkg::REG_SEQ_ENABLE:  seq_en_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            lvl_reg <= button_level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= 1'b0;
            held_reg   <= '0;
            rel_reg    <= '0;
            mcount_reg <= '0;
            mbits_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            prev_reg   <= prev_next;
            held_reg   <= held_next;
            rel_reg    <= rel_next;
            mcount_reg <= mcount_next;
            mbits_reg  <= mbits_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            sp_reg     <= sp_next;
            lp_reg     <= lp_next;
            kind_reg   <= kind_next;
            sv_reg     <= sv_next;
            slen_reg   <= slen_next;
            smarks_reg <= smarks_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign short_press     = sp_reg;
    assign long_press      = lp_reg;
    assign click_kind      = kind_reg;
    assign sequence_valid  = sv_reg;
    assign sequence_length = slen_reg;
    assign sequence_marks  = smarks_reg;

    `BPC_ASSERT(a_commit_fills_out, cmd.commit |=> out_valid_reg,
        "committed result missing from output register")
    `BPC_ASSERT(a_commit_needs_room, cmd.commit |-> !out_valid_reg || out_ready,
        "result committed over an untaken beat")

endmodule
